/* rtl/dcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_pkg
// shared constants, coefficient table and control type of the dual-channel
// low-pass fir
// ----------------------------------------------------------------------------
package dcf_pkg;

   localparam int TAP_COUNT_DEF      = 51;
   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int COEF_FRAC_BITS_DEF = 16;

   // coefficient table, unsigned q0.16, symmetric
   localparam int TABLE_TAPS = 51;
   localparam int TABLE_FRAC = 16;
   localparam int COEF_MAX_W = 24;

   localparam logic [11:0] COEF_Q16 [TABLE_TAPS] = '{
      12'd0,    12'd11,   12'd25,   12'd46,   12'd78,   12'd122,  12'd182,
      12'd261,  12'd360,  12'd481,  12'd623,  12'd787,  12'd970,  12'd1169,
      12'd1382, 12'd1603, 12'd1828, 12'd2051, 12'd2266, 12'd2468, 12'd2649,
      12'd2807, 12'd2934, 12'd3028, 12'd3086, 12'd3105, 12'd3086, 12'd3028,
      12'd2934, 12'd2807, 12'd2649, 12'd2468, 12'd2266, 12'd2051, 12'd1828,
      12'd1603, 12'd1382, 12'd1169, 12'd970,  12'd787,  12'd623,  12'd481,
      12'd360,  12'd261,  12'd182,  12'd122,  12'd78,   12'd46,   12'd25,
      12'd11,   12'd0
   };

   // mac controls from the sequencer
   typedef struct packed {
      logic clear;    // zero the accumulator
      logic mul_en;   // multiply the tail cell by the current coefficient
   } mac_ctrl_type;

   // coefficient j rescaled to frac fraction bits, zero beyond the table
   function automatic logic [COEF_MAX_W-1:0] coef_at(input int j, input int frac);
      logic [31:0] c;
      c = '0;
      if (j >= 0 && j < TABLE_TAPS) begin
         c = 32'(COEF_Q16[j]);
      end
      if (frac > TABLE_FRAC) begin
         c = c << (frac - TABLE_FRAC);
      end else if (frac < TABLE_FRAC) begin
         c = (c + (32'd1 << (TABLE_FRAC - frac - 1))) >> (TABLE_FRAC - frac);
      end
      return c[COEF_MAX_W-1:0];
   endfunction

endpackage

/* rtl/dcf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_cell
// one tap of the sample ring: holds a red/ir sample pair, passes it on
// ----------------------------------------------------------------------------
module dcf_cell #(
   parameter int WIDTH = 2 * dcf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);
   import dcf_pkg::*;

   logic [WIDTH-1:0] tap_ff;
   logic [WIDTH-1:0] tap_in;

   assign tap_in   = enable ? data_in : tap_ff;
   assign data_out = tap_ff;

   // history starts at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

endmodule

/* rtl/dcf_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_mac
// one channel: registered multiply, accumulate, round and saturate
// ----------------------------------------------------------------------------
module dcf_mac #(
   parameter int TAP_COUNT      = dcf_pkg::TAP_COUNT_DEF,
   parameter int SAMPLE_WIDTH   = dcf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = dcf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dcf_pkg::mac_ctrl_type              ctrl,
   input  logic [$clog2(TAP_COUNT)-1:0]       coef_idx,
   input  logic signed [SAMPLE_WIDTH-1:0]     sample,
   output logic signed [SAMPLE_WIDTH-1:0]     result
);
   import dcf_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int CW = COEF_FRAC_BITS;
   localparam int PW = SW + CW + 1;
   localparam int AW = PW + $clog2(TAP_COUNT) + 1;
   localparam logic signed [AW:0] HALF = {{(AW + 1 - CW){1'b0}}, 1'b1, {(CW - 1){1'b0}}};

   logic [COEF_MAX_W-1:0] coef_full;
   logic [CW-1:0]         coef;
   logic signed [PW-1:0]  prod_in;
   logic signed [PW-1:0]  prod_ff;
   logic                  prod_valid_ff;
   logic signed [AW-1:0]  acc_ff;
   logic signed [AW-1:0]  acc_in;
   logic signed [AW:0]    round_sum;
   logic signed [AW:0]    quot;
   logic [AW-SW+1:0]      upper;
   logic                  fits;

   assign coef_full = coef_at(int'(coef_idx), COEF_FRAC_BITS);
   assign coef      = coef_full[CW-1:0];
   assign prod_in   = sample * $signed({1'b0, coef});

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + AW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, then clamp to the sample range
   assign round_sum = (AW + 1)'(acc_ff) + HALF;
   assign quot      = round_sum >>> CW;
   assign upper     = quot[AW:SW-1];
   assign fits      = (&upper) || !(|upper);
   assign result    = fits ? quot[SW-1:0]
                    : (quot[AW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}});

endmodule

/* rtl/dual_channel_fir_lowpass_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_channel_fir_lowpass_core
// symmetric low-pass fir on the red and ir ac samples, dc passed through
// ----------------------------------------------------------------------------
// Each request beat carries one oximeter sample (red/ir ac, red/ir dc) and
// yields exactly one response beat. Both ac channels are filtered by the same
// fixed TAP_COUNT-tap low-pass fir with unsigned q0.COEF_FRAC_BITS
// coefficients; sums are rounded half up and saturated to the signed sample
// range, dc values come out untouched. The sample history sits in a ring of
// TAP_COUNT cells, each holding one red/ir pair and zero after reset. On
// accept the new pair is shifted in at the head; the ring then rotates once
// around, feeding its tail to one multiplier per channel, one tap per cycle.
// A beat passes from accept through TAP_COUNT multiply steps, an accumulate
// drain and a round/saturate step; no new request is taken meanwhile. The
// response sits in an output register, so the next request is taken while
// a result still waits; only the final round step holds off until the
// response register is free.
// ----------------------------------------------------------------------------
module dual_channel_fir_lowpass_core #(
   parameter int TAP_COUNT      = dcf_pkg::TAP_COUNT_DEF,
   parameter int SAMPLE_WIDTH   = dcf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = dcf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_ac_red_in,
   input  logic signed [SAMPLE_WIDTH-1:0] req_ac_ir_in,
   input  logic signed [SAMPLE_WIDTH-1:0] req_dc_red_in,
   input  logic signed [SAMPLE_WIDTH-1:0] req_dc_ir_in,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_ac_red_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_ac_ir_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_dc_red_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_dc_ir_out
);
   import dcf_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int IW = $clog2(TAP_COUNT);
   localparam int CELL_W = 2 * SW;

   typedef enum logic [1:0] {
      S_IDLE,     // waiting for a request beat
      S_RUN,      // one tap per cycle, ring rotating
      S_DRAIN,    // last product into the accumulator
      S_FINISH    // round, saturate, load the response register
   } state_type;

   state_type              state_ff, state_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]   ac_red_ff, ac_red_in;
   logic signed [SW-1:0]   ac_ir_ff, ac_ir_in;
   logic signed [SW-1:0]   dc_red_ff, dc_red_in;
   logic signed [SW-1:0]   dc_ir_ff, dc_ir_in;
   logic signed [SW-1:0]   dc_red_hold_ff, dc_red_hold_in;
   logic signed [SW-1:0]   dc_ir_hold_ff, dc_ir_hold_in;

   logic                   req_fire;
   logic                   rsp_free;
   logic                   ring_en;
   logic [CELL_W-1:0]      ring_head;
   logic [CELL_W-1:0]      ring [TAP_COUNT];
   logic [CELL_W-1:0]      ring_tail;
   mac_ctrl_type           mac_ctrl;
   logic signed [SW-1:0]   red_result;
   logic signed [SW-1:0]   ir_result;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // ring of sample cells: shift in on accept, rotate during the run
   assign ring_en   = req_fire || (state_ff == S_RUN);
   assign ring_tail = ring[TAP_COUNT-1];
   assign ring_head = req_fire ? {req_ac_red_in, req_ac_ir_in} : ring_tail;

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
      dcf_cell #(
         .WIDTH   (CELL_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (ring_en),
         .data_in  ((k == 0) ? ring_head : ring[(k == 0) ? 0 : k - 1]),
         .data_out (ring[k])
      );
   end

   // tail holds x[n-idx] while idx counts down from TAP_COUNT-1
   assign mac_ctrl.clear  = req_fire;
   assign mac_ctrl.mul_en = (state_ff == S_RUN);

   dcf_mac #(
      .TAP_COUNT      (TAP_COUNT),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac_red (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .coef_idx (idx_ff),
      .sample   (ring_tail[CELL_W-1:SW]),
      .result   (red_result)
   );

   dcf_mac #(
      .TAP_COUNT      (TAP_COUNT),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac_ir (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .coef_idx (idx_ff),
      .sample   (ring_tail[SW-1:0]),
      .result   (ir_result)
   );

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      ac_red_in      = ac_red_ff;
      ac_ir_in       = ac_ir_ff;
      dc_red_in      = dc_red_ff;
      dc_ir_in       = dc_ir_ff;
      dc_red_hold_in = dc_red_hold_ff;
      dc_ir_hold_in  = dc_ir_hold_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in       = S_RUN;
               idx_in         = IW'(TAP_COUNT - 1);
               dc_red_hold_in = req_dc_red_in;
               dc_ir_hold_in  = req_dc_ir_in;
            end
         end
         S_RUN: begin
            if (idx_ff == '0) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // wait until the previous response beat has left
            if (rsp_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               ac_red_in    = red_result;
               ac_ir_in     = ir_result;
               dc_red_in    = dc_red_hold_ff;
               dc_ir_in     = dc_ir_hold_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         ac_red_ff      <= ac_red_in;
         ac_ir_ff       <= ac_ir_in;
         dc_red_ff      <= dc_red_in;
         dc_ir_ff       <= dc_ir_in;
         dc_red_hold_ff <= dc_red_hold_in;
         dc_ir_hold_ff  <= dc_ir_hold_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ac_red_out = ac_red_ff;
   assign rsp_ac_ir_out  = ac_ir_ff;
   assign rsp_dc_red_out = dc_red_ff;
   assign rsp_dc_ir_out  = dc_ir_ff;

`ifndef NO_ASSERTIONS
   // an accepted beat always starts a run at the top tap
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_RUN) && (idx_ff == IW'(TAP_COUNT - 1)))
      else $error("accepted beat did not start a run");

   // the run ends exactly after the last tap
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) && (idx_ff == '0) |=> (state_ff == S_DRAIN))
      else $error("run did not end after the last tap");

   // a new response only appears out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the finish step");

   // finish holds while the response register is still occupied
   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && rsp_valid_ff && !rsp_ready |=> (state_ff == S_FINISH))
      else $error("finish overwrote a pending response");
`endif

endmodule

/* tb/sv/dual_channel_fir_lowpass_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_channel_fir_lowpass_core_test
// self-checking bench for the dual-channel low-pass fir core
// ----------------------------------------------------------------------------
// Every accepted request beat is run through a behavioral copy of the filter
// (two 50-deep sample histories, the package coefficient table, round half
// up, saturate) and the expected response is queued. Each response beat is
// popped against the oldest entry and compared field by field. Stimulus is a
// short directed run followed by random waveform segments (held levels,
// impulses, level/complement alternation, fine noise near zero, full-range noise),
// with random idle bursts on both the request and the response side.
// ----------------------------------------------------------------------------
module dual_channel_fir_lowpass_core_test;

   localparam int  CLK_PERIOD   = 10;
   localparam int  TAPS         = dcf_pkg::TAP_COUNT_DEF;
   localparam int  HIST_DEPTH   = TAPS - 1;
   localparam int  SW           = dcf_pkg::SAMPLE_WIDTH_DEF;
   localparam int  FRAC         = dcf_pkg::COEF_FRAC_BITS_DEF;
   localparam int  RANDOM_ITEMS = 650;
   localparam int  QUIET_ITEMS  = 100;   // final stretch with no idling at all
   localparam int  DRAIN_CYCLES = 2 * (TAPS + 3);
   localparam int  CYCLE_LIMIT  = 400_000;

   typedef logic signed [SW-1:0] sample_type;

   // one response beat as the core should produce it
   typedef struct packed {
      sample_type ac_red;
      sample_type ac_ir;
      sample_type dc_red;
      sample_type dc_ir;
   } oxi_result_type;

   // waveform shapes used to build random segments
   typedef enum int {
      SHAPE_NOISE,
      SHAPE_HOLD,
      SHAPE_IMPULSE,
      SHAPE_ALTERNATE,
      SHAPE_FINE
   } wave_shape_type;

   // ------------------------------------------------------------------------
   // scoreboard: filter predictor plus queue of pending responses
   // ------------------------------------------------------------------------
   class fir_scoreboard;
      sample_type     red_taps [HIST_DEPTH];
      sample_type     ir_taps  [HIST_DEPTH];
      oxi_result_type pending_results [$];
      int             failures;
      int             checked;

      function new();
         foreach (red_taps[k]) begin
            red_taps[k] = '0;
            ir_taps[k]  = '0;
         end
         failures = 0;
         checked  = 0;
      endfunction

      // fir sum of the newest sample and the history, rounded and clamped
      function sample_type lowpass_sum(sample_type x, sample_type taps [HIST_DEPTH]);
         longint acc;
         longint coef;
         longint rounded;
         acc = 0;
         for (int j = 0; j < TAPS; j++) begin
            coef = (j < dcf_pkg::TABLE_TAPS) ? longint'(dcf_pkg::COEF_Q16[j]) : 0;
            acc += coef * ((j == 0) ? longint'(x) : longint'(taps[j-1]));
         end
         // arithmetic shift gives the floor, so this is round half up
         rounded = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
         if (rounded > longint'((1 << (SW - 1)) - 1)) begin
            rounded = (1 << (SW - 1)) - 1;
         end else if (rounded < -longint'(1 << (SW - 1))) begin
            rounded = -longint'(1 << (SW - 1));
         end
         return sample_type'(rounded);
      endfunction

      function void note_sample(sample_type ac_red, sample_type ac_ir,
                                sample_type dc_red, sample_type dc_ir);
         oxi_result_type want;
         want.ac_red = lowpass_sum(ac_red, red_taps);
         want.ac_ir  = lowpass_sum(ac_ir, ir_taps);
         want.dc_red = dc_red;
         want.dc_ir  = dc_ir;
         pending_results.push_back(want);
         for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            red_taps[k] = red_taps[k-1];
            ir_taps[k]  = ir_taps[k-1];
         end
         red_taps[0] = ac_red;
         ir_taps[0]  = ac_ir;
      endfunction

      function void check_result(sample_type ac_red, sample_type ac_ir,
                                 sample_type dc_red, sample_type dc_ir);
         oxi_result_type want;
         checked++;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("response %0d arrived with nothing pending: %0d %0d %0d %0d",
                        checked, ac_red, ac_ir, dc_red, dc_ir);
            end
         end else begin
            want = pending_results.pop_front();
            if (want.ac_red !== ac_red || want.ac_ir !== ac_ir ||
                want.dc_red !== dc_red || want.dc_ir !== dc_ir) begin
               failures++;
               if (failures <= 10) begin
                  $display("response %0d mismatch: want ac_red %0d ac_ir %0d dc_red %0d dc_ir %0d",
                           checked, want.ac_red, want.ac_ir, want.dc_red, want.dc_ir);
                  $display("                        got  ac_red %0d ac_ir %0d dc_red %0d dc_ir %0d",
                           ac_red, ac_ir, dc_red, dc_ir);
               end
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset and interface signals, all known from time zero
   // ------------------------------------------------------------------------
   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   sample_type req_ac_red_in = '0;
   sample_type req_ac_ir_in  = '0;
   sample_type req_dc_red_in = '0;
   sample_type req_dc_ir_in  = '0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   sample_type rsp_ac_red_out;
   sample_type rsp_ac_ir_out;
   sample_type rsp_dc_red_out;
   sample_type rsp_dc_ir_out;

   fir_scoreboard sb = new();

   // idle odds: zero means no idling, n means a one-in-n burst chance per check
   int send_idle_odds = 0;
   int rsp_stall_odds = 0;
   int rsp_stall_left = 0;
   int cycle_count    = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   dual_channel_fir_lowpass_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ac_red_in  (req_ac_red_in),
      .req_ac_ir_in   (req_ac_ir_in),
      .req_dc_red_in  (req_dc_red_in),
      .req_dc_ir_in   (req_dc_ir_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ac_red_out (rsp_ac_red_out),
      .rsp_ac_ir_out  (rsp_ac_ir_out),
      .rsp_dc_red_out (rsp_dc_red_out),
      .rsp_dc_ir_out  (rsp_dc_ir_out)
   );

   // ------------------------------------------------------------------------
   // response side: check accepted beats, stall ready in random bursts
   // ------------------------------------------------------------------------
   // values read here are the ones in force before this edge's updates
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_ac_red_out, rsp_ac_ir_out, rsp_dc_red_out, rsp_dc_ir_out);
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
         // start a burst of random length with ready held low
         rsp_stall_left <= $urandom_range(1, 18) - 1;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // present one beat and hold it until the core takes it; valid stays high
   // across back-to-back beats so it never sees two updates in one step
   task automatic send_sample(sample_type ac_red, sample_type ac_ir,
                              sample_type dc_red, sample_type dc_ir);
      req_valid     <= 1'b1;
      req_ac_red_in <= ac_red;
      req_ac_ir_in  <= ac_ir;
      req_dc_red_in <= dc_red;
      req_dc_ir_in  <= dc_ir;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(ac_red, ac_ir, dc_red, dc_ir);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every queued response is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   function automatic sample_type pick_level();
      case ($urandom_range(0, 5))
         0:       return sample_type'(16'sh7fff);
         1:       return sample_type'(16'sh8000);
         2:       return sample_type'(1);
         3:       return sample_type'(-1);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic sample_type pick_dc();
      case ($urandom_range(0, 7))
         0:       return sample_type'(16'sh7fff);
         1:       return sample_type'(16'sh8000);
         2:       return sample_type'(0);
         3:       return sample_type'(-1);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // sample number idx of a segment with the given shape and level
   function automatic sample_type shape_sample(wave_shape_type shape, int idx,
                                               sample_type level);
      case (shape)
         SHAPE_HOLD:      return level;
         SHAPE_IMPULSE:   return (idx == 0) ? level : sample_type'(0);
         SHAPE_ALTERNATE: return idx[0] ? ~level : level;
         SHAPE_FINE:      return sample_type'(int'($urandom_range(0, 8)) - 4);
         default:         return sample_type'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int             random_sent;
      int             segment;
      int             seg_len;
      wave_shape_type red_shape;
      wave_shape_type ir_shape;
      sample_type     red_level;
      sample_type     ir_level;

      random_sent = 0;
      segment     = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: start-up from empty history, field extremes, sign patterns
      send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_sample(16'sh0000, 16'sh0000, 16'shffff, 16'sh0001);
      send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_sample(16'sh0001, 16'shffff, 16'sh0001, 16'shffff);
      send_sample(16'shffff, 16'sh0001, 16'sh5555, 16'shaaaa);
      send_sample(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
      send_sample(16'shaaaa, 16'sh5555, 16'sh0000, 16'sh0000);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
      send_sample(16'sh8000, 16'sh8000, 16'sh1234, 16'shedcb);
      send_sample(16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
      send_sample(16'sh0002, 16'shfffe, 16'sh4000, 16'shc000);
      send_sample(16'sh4000, 16'shc000, 16'sh0000, 16'sh0000);
      send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

      // hold off until the core has returned everything
      drain_results();

      while (random_sent < RANDOM_ITEMS) begin
         red_shape      = wave_shape_type'($urandom_range(0, 4));
         ir_shape       = wave_shape_type'($urandom_range(0, 4));
         red_level      = pick_level();
         ir_level       = pick_level();
         seg_len        = $urandom_range(20, 70);
         send_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
         rsp_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);

         // first two segments push full-scale levels through every tap so
         // the slight excess of unity gain drives both channels into clamp
         if (segment == 0) begin
            red_shape = SHAPE_HOLD;
            ir_shape  = SHAPE_HOLD;
            red_level = sample_type'(16'sh7fff);
            ir_level  = sample_type'(16'sh8000);
            seg_len   = TAPS + 6;
         end else if (segment == 1) begin
            red_shape = SHAPE_HOLD;
            ir_shape  = SHAPE_HOLD;
            red_level = sample_type'(16'sh8000);
            ir_level  = sample_type'(16'sh7fff);
            seg_len   = TAPS + 6;
         end

         for (int idx = 0; idx < seg_len && random_sent < RANDOM_ITEMS; idx++) begin
            // last stretch runs flat out on both sides
            if (random_sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
               send_idle_odds = 0;
               rsp_stall_odds = 0;
            end
            if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1) begin
               pause_sender($urandom_range(1, 18));
            end
            send_sample(shape_sample(red_shape, idx, red_level),
                        shape_sample(ir_shape, idx, ir_level),
                        pick_dc(), pick_dc());
            random_sent++;
         end

         segment++;
         if (segment == 6) begin
            drain_results();
         end
      end

      // wait out everything still in flight, then a little more
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
